FILE: rtl/core/dmic_pkg.sv
// ----------------------------------------------------------------------------
// dmic_pkg
// Shared types and constants for the direct-mapped ID cache: slot layout,
// opcodes and the write-back and result records.
// ----------------------------------------------------------------------------
package dmic_pkg;

	// ENTRIES is a power of two; the index is the low bits of the folded key.
	localparam int ENTRIES     = 1024;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int HANDLE_BITS = 32;
	localparam int HANDLE_W    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
	localparam int KEY_W       = 64;
	localparam int FOLD_SHIFT  = 32;
	localparam int COUNT_W     = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef struct packed {
		logic                valid;
		logic [COUNT_W-1:0]  count;
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   wr;
		entry_t entry;
	} wb_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] handle;
	} result_t;

	function automatic logic [IDX_W-1:0] slot_index(input logic [KEY_W-1:0] k);
		logic [FOLD_SHIFT-1:0] folded;
		folded = k[FOLD_SHIFT-1:0] | k[KEY_W-1:FOLD_SHIFT];
		return folded[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/core/dmic_ram.sv
// ----------------------------------------------------------------------------
// dmic_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dmic_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/dmic_slot_update.sv
// ----------------------------------------------------------------------------
// dmic_slot_update
// Read-modify-write logic for one slot: works out the new slot contents and
// the lookup result from the slot as read and the request.
// ----------------------------------------------------------------------------
module dmic_slot_update (
	input  dmic_pkg::op_t           op,
	input  logic [63:0]             key,
	input  logic [31:0]             handle_in,
	input  logic                    already_present,
	input  dmic_pkg::entry_t        slot,
	output dmic_pkg::wb_t           wb,
	output dmic_pkg::result_t       res
);

	import dmic_pkg::*;

	logic key_zero;
	logic key_eq;
	logic [COUNT_W-1:0] cnt_dec;

	assign key_zero = (slot.key == '0);
	assign key_eq   = (slot.key == key);
	assign cnt_dec  = (slot.count == '0) ? '0 : slot.count - 1'b1;

	always_comb begin
		wb.wr      = 1'b0;
		wb.entry   = slot;
		res.hit    = 1'b0;
		res.handle = '0;
		case (op)
			OP_INSERT: begin
				if (!already_present && !(!key_zero && key_eq)) begin
					wb.wr = 1'b1;
					if (key_zero) begin
						wb.entry.key    = key;
						wb.entry.handle = HANDLE_W'(handle_in);
						wb.entry.count  = COUNT_W'(1);
						wb.entry.valid  = 1'b1;
					end else begin
						// different key in the slot: count it, drop the slot
						if (slot.count != COUNT_MAX) begin
							wb.entry.count = slot.count + 1'b1;
						end
						wb.entry.valid = 1'b0;
					end
				end
			end
			OP_LOOKUP: begin
				if (slot.valid && key_eq) begin
					res.hit    = 1'b1;
					res.handle = 32'(slot.handle);
				end
			end
			OP_REMOVE: begin
				wb.wr          = 1'b1;
				wb.entry.count = cnt_dec;
				if (cnt_dec == '0) begin
					wb.entry.key   = '0;
					wb.entry.valid = 1'b0;
				end
			end
			default: begin
				wb.wr = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/direct_mapped_id_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_id_cache
// Direct-mapped cache of 64-bit keys to handles with per-slot collision count.
// ----------------------------------------------------------------------------
// Each request beat is a read-modify-write: the slot memory is read first
// (synchronous read), then the updated slot is written back and the result
// beat registered, so a new request is not taken while one is in flight.
// One result beat comes out per request, in order; a result beat held by
// out_stall holds off the next request until it is taken.
// After reset the slot memory is cleared one entry per cycle over all ENTRIES
// (1024) slots, with the request side stalled meanwhile.
module direct_mapped_id_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key,
	input  logic [31:0] handle_in,
	input  logic        already_present,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] handle_out
);

	import dmic_pkg::*;

	logic             accept;
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             busy_s1;
	op_t              op_s1;
	logic [63:0]      key_s1;
	logic [31:0]      handle_s1;
	logic             present_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             out_valid_q;
	logic             hit_q;
	logic [31:0]      handle_q;

	entry_t           rd_slot;
	wb_t              wb;
	result_t          res;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;

	assign in_stall = clr_busy_q | busy_s1 | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_s1     <= accept;
			out_valid_q <= busy_s1 | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(opcode);
			key_s1     <= key;
			handle_s1  <= handle_in;
			present_s1 <= already_present;
			idx_s1     <= slot_index(key);
		end
		if (busy_s1) begin
			hit_q    <= res.hit;
			handle_q <= res.handle;
		end
	end

	dmic_slot_update u_update (
		.op              (op_s1),
		.key             (key_s1),
		.handle_in       (handle_s1),
		.already_present (present_s1),
		.slot            (rd_slot),
		.wb              (wb),
		.res             (res)
	);

	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = busy_s1 & wb.wr;
			ram_waddr = idx_s1;
			ram_wdata = wb.entry;
		end
	end

	dmic_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_index(key)),
		.rdata (rd_slot)
	);

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign handle_out = handle_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> !busy_s1)
		else $error("request overlapped the slot read-modify-write");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> out_valid_q)
		else $error("finished request left no result beat");

	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !clr_busy_q)
		else $error("request processed during memory clear");

	a_miss_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !hit_q |-> handle_q == '0)
		else $error("miss beat carries a nonzero handle");

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> $past(clr_idx_q) == IDX_W'(ENTRIES - 1))
		else $error("memory clear ended early");

endmodule
